>>> hw/rtl/srt_pkg.sv
// Package with types, constants and state codes for the station signal table.
package srt_pkg;

  localparam int TableDepthDefault = 32;
  localparam logic [15:0] IntervalReset = 16'd5;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam int SumW = 25;
  localparam int QuotW = 9;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef struct packed {
    logic        op;
    logic [47:0] station_mac;
    logic signed [7:0] signal_dbm;
    logic        bad_fcs;
    logic [7:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [47:0] report_mac;
    logic signed [7:0] rssi_avg;
    logic [7:0]  report_channel;
    logic [15:0] report_samples;
    logic        last_entry;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RPT_FIND,
    ST_RPT_READ,
    ST_RPT_DIV,
    ST_RPT_OUT
  } state_t;

endpackage

>>> hw/rtl/srt_divider.sv
// Restoring divider that divides a nonnegative sum by a count one bit per cycle.
module srt_divider
  import srt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SumW-1:0]        dividend,
  input  logic [15:0]            divisor,
  output logic                   done,
  output logic [QuotW-1:0]       quotient
);

  localparam int CntW = $clog2(SumW + 1);

  logic [SumW-1:0] quot;
  logic [16:0]     rem;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [16:0]     rem_shift;
  logic [17:0]     diff;

  assign rem_shift = {rem[15:0], quot[SumW-1]};
  assign diff = {1'b0, rem_shift} - {2'b0, divisor};
  assign quotient = quot[QuotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(SumW);
        quot <= dividend;
        rem <= '0;
      end else if (busy) begin
        if (diff[17]) begin
          rem <= rem_shift;
          quot <= {quot[SumW-2:0], 1'b0};
        end else begin
          rem <= diff[16:0];
          quot <= {quot[SumW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/station_rssi_table.sv
// Top level of the station signal table with a scanned entry store and a report walker.
//  channel | valid    | stall    | payload
//  input   | in_valid | in_stall | in_item (in_item_t)
//  output  | out_valid| out_stall| out_item (out_item_t)
//  config  | cfg_we   | -        | cfg_data (report_interval)
// A packet item with a good FCS scans the table one entry per cycle; a bad one is dropped.
// A report skips empty entries and, per station, reads the entry, runs the 25-step
// serial divider and presents the output item; output stalls lengthen it.
// Valid marks and the seconds counter clear at reset. A stalled output item holds the
// walk; no input is taken meanwhile.
module station_rssi_table
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [15:0] cfg_data
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  logic [47:0]     mem_mac [TABLE_DEPTH];
  logic [SumW-1:0] mem_sum [TABLE_DEPTH];
  logic [15:0]     mem_cnt [TABLE_DEPTH];
  logic [7:0]      mem_chan [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;

  state_t state, state_next;
  logic [15:0] interval, elapsed;
  in_item_t    req;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] ix;
  logic        hit_found, free_found;
  logic [IdxW-1:0] hit_idx, free_idx, last_idx;
  logic        new_entry;
  logic [47:0] rd_mac;
  logic [SumW-1:0] rd_sum;
  logic [15:0] rd_cnt;
  logic [7:0]  rd_chan;
  logic        div_start, div_done;
  logic [QuotW-1:0] quot;
  logic [15:0] elapsed_inc;
  logic [SumW-1:0] abs_sum;
  logic            neg_sum;
  logic [QuotW-1:0] avg_q;

  assign ix = idx[IdxW-1:0];
  assign elapsed_inc = (elapsed == CountMax) ? elapsed : elapsed + 16'd1;
  assign in_stall = (state != ST_IDLE);

  srt_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(abs_sum),
    .divisor(rd_cnt), .done(div_done), .quotient(quot)
  );

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.op == OP_TICK) begin
            if ((elapsed_inc >= interval) && (|valid)) state_next = ST_RPT_FIND;
          end else if (!in_item.bad_fcs) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (valid[ix] && mem_mac[ix] == req.station_mac) state_next = ST_UPDATE;
        else if (idx == CntW'(TABLE_DEPTH - 1)) begin
          state_next = (free_found || !valid[ix]) ? ST_UPDATE : ST_IDLE;
        end
      end
      ST_UPDATE: state_next = ST_IDLE;
      ST_RPT_FIND: begin
        if (valid[ix]) state_next = ST_RPT_READ;
        else if (idx == CntW'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_RPT_READ: begin
        div_start = 1'b1;
        state_next = ST_RPT_DIV;
      end
      ST_RPT_DIV: if (div_done) state_next = ST_RPT_OUT;
      ST_RPT_OUT: begin
        if (!out_stall) state_next = (ix == last_idx) ? ST_IDLE : ST_RPT_FIND;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      interval <= IntervalReset;
      elapsed <= '0;
      valid <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) interval <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          hit_found <= 1'b0;
          free_found <= 1'b0;
          if (in_valid) begin
            req <= in_item;
            if (in_item.op == OP_TICK) begin
              elapsed <= elapsed_inc;
              for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (valid[i]) last_idx <= IdxW'(i);
              end
            end
          end
        end
        ST_SCAN: begin
          if (valid[ix] && mem_mac[ix] == req.station_mac) begin
            hit_found <= 1'b1;
            hit_idx <= ix;
          end else begin
            if (!valid[ix] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= ix;
            end
            idx <= idx + 1'b1;
          end
        end
        ST_UPDATE: begin
          valid[new_entry ? free_idx : hit_idx] <= 1'b1;
        end
        ST_RPT_FIND: if (!valid[ix]) idx <= idx + 1'b1;
        ST_RPT_DIV: if (div_done) out_valid <= 1'b1;
        ST_RPT_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            valid[ix] <= 1'b0;
            idx <= idx + 1'b1;
            if (ix == last_idx) elapsed <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign new_entry = !hit_found;

  always_ff @(posedge clk) begin
    logic [IdxW-1:0] w;
    logic [15:0] c;
    logic [SumW-1:0] s;
    w = new_entry ? free_idx : hit_idx;
    c = new_entry ? 16'd0 : mem_cnt[w];
    s = new_entry ? '0 : mem_sum[w];
    if (state == ST_UPDATE) begin
      mem_mac[w] <= req.station_mac;
      mem_chan[w] <= req.channel;
      if (c != CountMax) begin
        mem_cnt[w] <= c + 16'd1;
        mem_sum[w] <= s - SumW'(req.signal_dbm);
      end else begin
        mem_cnt[w] <= c;
        mem_sum[w] <= s;
      end
    end
    if (state == ST_RPT_FIND) begin
      rd_mac <= mem_mac[ix];
      rd_sum <= mem_sum[ix];
      rd_cnt <= mem_cnt[ix];
      rd_chan <= mem_chan[ix];
    end
  end

  assign neg_sum = rd_sum[SumW-1];
  assign abs_sum = neg_sum ? -rd_sum : rd_sum;
  assign avg_q = neg_sum ? quot : -quot;

  always_ff @(posedge clk) begin
    if (state == ST_RPT_DIV && div_done) begin
      out_item.report_mac <= rd_mac;
      out_item.rssi_avg <= avg_q[7:0];
      out_item.report_channel <= rd_chan;
      out_item.report_samples <= rd_cnt;
      out_item.last_entry <= (ix == last_idx);
    end
  end

endmodule

>>> dv/tb_station_rssi_table.sv
// Self-checking testbench for the station signal table with a built-in table predictor.
module tb_station_rssi_table
  import srt_pkg::*;
();

  localparam int Depth = 32;
  localparam int StallLimit = 20000;
  localparam int InW = $bits(in_item_t);

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic [15:0] cfg_data;

  station_rssi_table #(.TABLE_DEPTH(Depth)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Predicted table contents.
  logic [15:0] interval_q;
  logic        tab_valid [Depth];
  logic [47:0] tab_mac [Depth];
  logic signed [24:0] tab_sum [Depth];
  logic [15:0] tab_count [Depth];
  logic [7:0]  tab_chan [Depth];
  logic [15:0] seconds_q;

  out_item_t report_q[$];
  int errors;
  int idle_cycles;
  bit no_idle;
  bit hold_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void predict_item(in_item_t it);
    int slot;
    int free_slot;
    int last;
    int q;
    out_item_t r;
    slot = -1;
    free_slot = -1;
    last = -1;
    if (it.op == OP_PACKET) begin
      if (it.bad_fcs) return;
      for (int i = 0; i < Depth; i++) begin
        if (tab_valid[i]) begin
          if (tab_mac[i] == it.station_mac && slot < 0) slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (slot < 0) begin
        if (free_slot < 0) return;
        slot = free_slot;
        tab_valid[slot] = 1'b1;
        tab_mac[slot] = it.station_mac;
        tab_sum[slot] = '0;
        tab_count[slot] = '0;
      end
      tab_chan[slot] = it.channel;
      if (tab_count[slot] != CountMax) begin
        tab_sum[slot] = tab_sum[slot] - 25'(it.signal_dbm);
        tab_count[slot]++;
      end
    end else begin
      if (seconds_q != 16'hFFFF) seconds_q++;
      if (seconds_q < interval_q) return;
      for (int i = 0; i < Depth; i++) if (tab_valid[i]) last = i;
      if (last < 0) return;
      for (int i = 0; i < Depth; i++) begin
        if (tab_valid[i]) begin
          q = int'(tab_sum[i]) / int'(tab_count[i]);
          r.report_mac = tab_mac[i];
          r.rssi_avg = 8'(-q);
          r.report_channel = tab_chan[i];
          r.report_samples = tab_count[i];
          r.last_entry = (i == last);
          report_q.push_back(r);
          tab_valid[i] = 1'b0;
        end
      end
      seconds_q = '0;
    end
  endfunction

  task automatic send_item(in_item_t it);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic send_packet(logic [47:0] mac, logic [7:0] sig, logic bad, logic [7:0] ch);
    in_item_t it;
    it.op = OP_PACKET;
    it.station_mac = mac;
    it.signal_dbm = sig;
    it.bad_fcs = bad;
    it.channel = ch;
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it = in_item_t'(InW'({$urandom, $urandom, $urandom}));
    it.op = OP_TICK;
    send_item(it);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_interval(logic [15:0] v);
    drain_reports();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    interval_q = v;
  endtask

  // Output side: random stalls, and a long hold when requested.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_out || (!no_idle && $urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report item %p", $time, out_item);
        errors++;
      end else begin
        exp_r = report_q.pop_front();
        if (out_item.report_mac !== exp_r.report_mac) begin
          $display("%0t: report_mac expected %h actual %h", $time, exp_r.report_mac,
                   out_item.report_mac);
          errors++;
        end
        if (out_item.rssi_avg !== exp_r.rssi_avg) begin
          $display("%0t: rssi_avg expected %0d actual %0d", $time, exp_r.rssi_avg,
                   out_item.rssi_avg);
          errors++;
        end
        if (out_item.report_channel !== exp_r.report_channel) begin
          $display("%0t: report_channel expected %0d actual %0d", $time,
                   exp_r.report_channel, out_item.report_channel);
          errors++;
        end
        if (out_item.report_samples !== exp_r.report_samples) begin
          $display("%0t: report_samples expected %0d actual %0d", $time,
                   exp_r.report_samples, out_item.report_samples);
          errors++;
        end
        if (out_item.last_entry !== exp_r.last_entry) begin
          $display("%0t: last_entry expected %0d actual %0d", $time, exp_r.last_entry,
                   out_item.last_entry);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && report_q.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_directed();
    write_interval(16'd2);
    send_tick();
    send_tick();
    send_packet(48'h0, 8'h80, 1'b0, 8'h00);
    send_packet(48'hFFFF_FFFF_FFFF, 8'h7F, 1'b0, 8'hFF);
    send_packet(48'h0, 8'h7F, 1'b0, 8'h0B);
    send_packet(48'h1234_5678_9ABC, 8'hF6, 1'b1, 8'h55);
    send_packet(48'hAAAA_5555_AAAA, 8'hF5, 1'b0, 8'h55);
    send_packet(48'hAAAA_5555_AAAA, 8'hF6, 1'b0, 8'hAA);
    send_packet(48'h5555_AAAA_5555, 8'h00, 1'b0, 8'h01);
    send_tick();
    write_interval(16'd1);
    send_packet(48'h0000_0000_0001, 8'hFF, 1'b0, 8'h06);
    send_tick();
    send_packet(48'h0000_0000_0002, 8'h01, 1'b0, 8'h06);
    send_tick();
  endtask

  task automatic test_table_full();
    write_interval(16'd3);
    for (int i = 0; i < Depth + 3; i++)
      send_packet(48'hC0DE_0000_0000 + 48'(i), 8'($urandom), 1'b0, 8'($urandom));
    send_tick();
    send_tick();
    send_tick();
  endtask

  task automatic test_back_pressure();
    write_interval(16'd1);
    for (int i = 0; i < 8; i++)
      send_packet(48'hBEEF_0000_0000 + 48'(i), 8'($urandom), 1'b0, 8'($urandom));
    hold_out = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_out = 1'b0;
      end
      begin
        send_tick();
        send_packet(48'hBEEF_0000_0100, 8'h10, 1'b0, 8'h03);
        send_tick();
      end
    join
  endtask

  task automatic test_random();
    logic [47:0] pool [8];
    for (int i = 0; i < 8; i++) pool[i] = 48'({$urandom, $urandom});
    for (int n = 0; n < 150; n++) begin
      if (n == 60) write_interval(16'($urandom_range(1, 4)));
      if (n == 130) write_interval(16'd0);
      no_idle = (n >= 80 && n < 120);
      if ($urandom_range(99) < 18) begin
        send_tick();
      end else if ($urandom_range(99) < 80) begin
        send_packet(pool[$urandom_range(7)], 8'($urandom), $urandom_range(9) == 0,
                    8'($urandom));
      end else begin
        send_packet(48'({$urandom, $urandom}), 8'($urandom), 1'($urandom),
                    8'($urandom));
      end
    end
    no_idle = 1'b0;
    write_interval(16'd1);
    send_tick();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    no_idle = 1'b0;
    hold_out = 1'b0;
    interval_q = IntervalReset;
    seconds_q = '0;
    for (int i = 0; i < Depth; i++) tab_valid[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_table_full();
    test_back_pressure();
    test_random();
    drain_reports();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
